// ===== hw/rtl/plec_pkg.sv =====
// Shared types, sizes and codes for the positional list engine.
package plec_pkg;

  // Store size and derived widths
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 16;
  localparam int COUNT_W  = 7;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_RSVD   = 2'd3
  } stat_t;

  // Action broadcast to every cell of the row
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_READ = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t            kind;
    logic [IDX_W-1:0]    tgt;
    logic [DATA_W-1:0]   value;
  } cell_cmd_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_GATHER = 2'd2
  } state_t;

endpackage

// ===== hw/rtl/positional_list_engine_core.sv =====
// Top level of the positional list engine: sequencer, length and the cell row.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | in_operation, in_position, in_value
//  out_    | output    | out_valid / out_ready | out_read_value, out_status, out_count
//
// Each request is accepted in idle, then passes an execute state in which every cell of the
// row shifts, loads or taps in parallel, and a gather state that ORs the cell taps
// into the result register. A new request is accepted while a result waits.
// Reset clears the element count, the sequencer and the result valid; cell
// contents are not reset. A stalled result holds the sequencer in the gather state.
module positional_list_engine_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_operation,
  input  logic signed [plec_pkg::POS_W-1:0]   in_position,
  input  logic signed [plec_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [plec_pkg::DATA_W-1:0]  out_read_value,
  output logic [1:0]                          out_status,
  output logic [plec_pkg::COUNT_W-1:0]        out_count
);

  localparam int N = plec_pkg::CAPACITY;

  plec_pkg::state_t               state_r, state_nxt;
  plec_pkg::op_t                  op_r;
  logic [plec_pkg::POS_W-1:0]     pos_r;
  logic [plec_pkg::DATA_W-1:0]    val_r;
  logic [plec_pkg::LEN_W-1:0]     len_r, len_nxt;
  plec_pkg::stat_t                stat_r, stat_nxt;
  logic                           out_valid_r;
  logic [plec_pkg::DATA_W-1:0]    out_value_r;
  plec_pkg::stat_t                out_status_r;
  logic [plec_pkg::COUNT_W-1:0]   out_count_r;

  logic                           accept;
  logic                           exec_en;
  logic                           gather_en;
  logic                           out_free;
  plec_pkg::cell_cmd_t            cmd;
  plec_pkg::cell_op_t             kind_dec;
  logic [plec_pkg::POS_W-1:0]     pos_mag;
  logic [plec_pkg::POS_W-1:0]     len_ext;
  logic [plec_pkg::POS_W-1:0]     at_sel;
  logic                           pos_neg;
  logic [plec_pkg::DATA_W-1:0]    cell_data [N];
  logic [plec_pkg::DATA_W-1:0]    cell_tap  [N];
  logic [plec_pkg::DATA_W-1:0]    tap_or;

  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plec_pkg::S_IDLE:   if (in_valid) state_nxt = plec_pkg::S_EXEC;
      plec_pkg::S_EXEC:   state_nxt = plec_pkg::S_GATHER;
      plec_pkg::S_GATHER: if (out_free) state_nxt = plec_pkg::S_IDLE;
      default:            state_nxt = plec_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    exec_en   = 1'b0;
    gather_en = 1'b0;
    unique case (state_r)
      plec_pkg::S_IDLE:   in_ready  = 1'b1;
      plec_pkg::S_EXEC:   exec_en   = 1'b1;
      plec_pkg::S_GATHER: gather_en = out_free;
      default:            in_ready  = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  // Decode the latched request against the current length
  assign pos_neg = pos_r[plec_pkg::POS_W-1];
  assign pos_mag = {1'b0, pos_r[plec_pkg::POS_W-2:0]};
  assign len_ext = plec_pkg::POS_W'(len_r);

  always_comb begin
    kind_dec = plec_pkg::CELL_HOLD;
    stat_nxt = plec_pkg::STAT_DONE;
    len_nxt  = len_r;
    at_sel   = pos_neg ? '0 : pos_mag;
    unique case (op_r)
      plec_pkg::OP_INSERT: begin
        if (len_r >= plec_pkg::LEN_W'(N)) begin
          stat_nxt = plec_pkg::STAT_FULL;
        end else begin
          if (at_sel > len_ext) at_sel = len_ext;
          kind_dec = plec_pkg::CELL_INS;
          len_nxt  = len_r + 1'b1;
        end
      end
      plec_pkg::OP_DELETE: begin
        if (pos_neg || pos_mag >= len_ext) begin
          stat_nxt = plec_pkg::STAT_ABSENT;
        end else begin
          kind_dec = plec_pkg::CELL_DEL;
          len_nxt  = len_r - 1'b1;
        end
      end
      plec_pkg::OP_READ: begin
        if (at_sel >= len_ext) begin
          stat_nxt = plec_pkg::STAT_ABSENT;
        end else begin
          kind_dec = plec_pkg::CELL_READ;
        end
      end
      plec_pkg::OP_CLEAR: begin
        len_nxt = '0;
      end
      default: begin
        len_nxt = len_r;
      end
    endcase
  end

  // Broadcast the action to the row only in the execute cycle
  always_comb begin
    cmd.kind  = exec_en ? kind_dec : plec_pkg::CELL_HOLD;
    cmd.tgt   = at_sel[plec_pkg::IDX_W-1:0];
    cmd.value = val_r;
  end

  // Cell row: each cell sees both neighbors
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [plec_pkg::DATA_W-1:0] left_d;
    logic [plec_pkg::DATA_W-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_data[g-1];
    end
    if (g == N - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_data[g+1];
    end
    plec_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .my_idx     (plec_pkg::IDX_W'(g)),
      .left_data  (left_d),
      .right_data (right_d),
      .data_out   (cell_data[g]),
      .tap_out    (cell_tap[g])
    );
  end

  // Collect the one live tap
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < N; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  // Latch the request payload; pass the taps only for a successful read
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= plec_pkg::op_t'(in_operation);
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (exec_en) begin
      stat_r <= stat_nxt;
    end
    if (gather_en) begin
      out_value_r  <= (op_r == plec_pkg::OP_READ && stat_r == plec_pkg::STAT_DONE) ?
                      tap_or : '0;
      out_status_r <= stat_r;
      out_count_r  <= plec_pkg::COUNT_W'(len_r);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plec_pkg::S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_en) begin
        len_r <= len_nxt;
      end
      if (gather_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;

endmodule

// ===== hw/rtl/plec_cell.sv =====
// One storage cell of the shifting element row.
module plec_cell (
  input  logic                          clk,
  input  plec_pkg::cell_cmd_t           cmd,
  input  logic [plec_pkg::IDX_W-1:0]    my_idx,
  input  logic [plec_pkg::DATA_W-1:0]   left_data,
  input  logic [plec_pkg::DATA_W-1:0]   right_data,
  output logic [plec_pkg::DATA_W-1:0]   data_out,
  output logic [plec_pkg::DATA_W-1:0]   tap_out
);

  logic [plec_pkg::DATA_W-1:0] data_r;
  logic [plec_pkg::DATA_W-1:0] data_nxt;
  logic [plec_pkg::DATA_W-1:0] tap_r;
  logic [plec_pkg::DATA_W-1:0] tap_nxt;

  // Pick the next content: shift up on insert, shift down on delete.
  // Hold the tap until the next read so a stalled result keeps its value.
  always_comb begin
    data_nxt = data_r;
    tap_nxt  = tap_r;
    unique case (cmd.kind)
      plec_pkg::CELL_INS: begin
        if (my_idx > cmd.tgt) begin
          data_nxt = left_data;
        end else if (my_idx == cmd.tgt) begin
          data_nxt = cmd.value;
        end
      end
      plec_pkg::CELL_DEL: begin
        if (my_idx >= cmd.tgt) begin
          data_nxt = right_data;
        end
      end
      plec_pkg::CELL_READ: begin
        tap_nxt = (my_idx == cmd.tgt) ? data_r : '0;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // Hold content and read tap
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    tap_r  <= tap_nxt;
  end

  assign data_out = data_r;
  assign tap_out  = tap_r;

endmodule
